### hw/rtl/dra_pkg.sv
// shared types and constants for the dns response address parser
package dra_pkg;

  // parse phase codes
  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_HEADER = 4'd1;
  localparam logic [3:0] PH_QLEN   = 4'd2;
  localparam logic [3:0] PH_QSKIP  = 4'd3;
  localparam logic [3:0] PH_QFIX   = 4'd4;
  localparam logic [3:0] PH_ALEN   = 4'd5;
  localparam logic [3:0] PH_ASKIP  = 4'd6;
  localparam logic [3:0] PH_APTR   = 4'd7;
  localparam logic [3:0] PH_AFIX   = 4'd8;
  localparam logic [3:0] PH_ALENHI = 4'd9;
  localparam logic [3:0] PH_ALENLO = 4'd10;
  localparam logic [3:0] PH_ADATA  = 4'd11;
  localparam logic [3:0] PH_DONE   = 4'd12;

  // message layout constants
  localparam logic [15:0] HEADER_BYTES  = 16'd12;
  localparam logic [15:0] QUESTION_TAIL = 16'd4;
  localparam logic [15:0] ANSWER_FIXED  = 16'd8;
  localparam logic [15:0] ADDR_BYTES    = 16'd4;
  localparam logic [7:0]  POINTER_MASK  = 8'hC0;

  // one input byte with its start flag
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } item_t;

  // one extracted address
  typedef struct packed {
    logic        valid;
    logic [31:0] ip_address;
    logic [15:0] answer_number;
  } res_t;

endpackage

### hw/rtl/dra_in_reg.sv
// input register stage holding one accepted byte
module dra_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dra_pkg::item_t in_item,
  input  logic           space,
  output logic           step,
  output dra_pkg::item_t item
);

  logic           valid_r;
  logic           valid_nxt;
  dra_pkg::item_t item_r;

  // advance when downstream has room for a possible result
  assign step     = valid_r && space;
  assign in_ready = !valid_r || step;
  assign item     = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (step) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

### hw/rtl/dra_parse_core.sv
// parse state machine: one byte per step, optional address result
module dra_parse_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  dra_pkg::item_t item,
  output dra_pkg::res_t  res
);

  logic [3:0]  phase_r, phase_nxt;
  logic [15:0] byte_counter_r, byte_counter_nxt;
  logic [15:0] questions_left_r, questions_left_nxt;
  logic [15:0] answers_left_r, answers_left_nxt;
  logic [15:0] data_length_r, data_length_nxt;
  logic [31:0] address_gather_r, address_gather_nxt;
  logic [15:0] answer_index_r, answer_index_nxt;

  // state after an optional restart
  logic [3:0]  cur_ph;
  logic [15:0] cur_bc, cur_ql, cur_al, cur_dl, cur_ai;
  logic [31:0] cur_ag;
  logic [15:0] bc_inc, bc_dec, dl_full;
  logic [31:0] ag_shift;
  logic [7:0]  b;

  assign b = item.data_byte;

  // a start flag restarts the parse at header byte 0
  always_comb begin
    if (item.first_byte) begin
      cur_ph = dra_pkg::PH_HEADER;
      cur_bc = '0;
      cur_ql = '0;
      cur_al = '0;
      cur_dl = '0;
      cur_ag = '0;
      cur_ai = '0;
    end else begin
      cur_ph = phase_r;
      cur_bc = byte_counter_r;
      cur_ql = questions_left_r;
      cur_al = answers_left_r;
      cur_dl = data_length_r;
      cur_ag = address_gather_r;
      cur_ai = answer_index_r;
    end
  end

  assign bc_inc   = cur_bc + 16'd1;
  assign bc_dec   = cur_bc - 16'd1;
  assign dl_full  = {cur_dl[15:8], b};
  assign ag_shift = {cur_ag[23:0], b};

  // next state and result
  always_comb begin
    phase_nxt          = cur_ph;
    byte_counter_nxt   = cur_bc;
    questions_left_nxt = cur_ql;
    answers_left_nxt   = cur_al;
    data_length_nxt    = cur_dl;
    address_gather_nxt = cur_ag;
    answer_index_nxt   = cur_ai;
    res.valid          = 1'b0;
    res.ip_address     = ag_shift;
    res.answer_number  = cur_ai;
    case (cur_ph)
      dra_pkg::PH_HEADER: begin
        if (cur_bc == 16'd4) begin
          questions_left_nxt = {b, 8'd0};
        end else if (cur_bc == 16'd5) begin
          questions_left_nxt = {cur_ql[15:8], b};
        end else if (cur_bc == 16'd6) begin
          answers_left_nxt = {b, 8'd0};
        end else if (cur_bc == 16'd7) begin
          answers_left_nxt = {cur_al[15:8], b};
        end
        byte_counter_nxt = bc_inc;
        if (bc_inc >= dra_pkg::HEADER_BYTES) begin
          if (questions_left_nxt != 16'd0) begin
            phase_nxt = dra_pkg::PH_QLEN;
          end else if (answers_left_nxt != 16'd0) begin
            phase_nxt = dra_pkg::PH_ALEN;
          end else begin
            phase_nxt = dra_pkg::PH_DONE;
          end
        end
      end
      dra_pkg::PH_QLEN: begin
        if (b == 8'd0) begin
          byte_counter_nxt = dra_pkg::QUESTION_TAIL;
          phase_nxt        = dra_pkg::PH_QFIX;
        end else begin
          byte_counter_nxt = {8'd0, b};
          phase_nxt        = dra_pkg::PH_QSKIP;
        end
      end
      dra_pkg::PH_QSKIP: begin
        byte_counter_nxt = bc_dec;
        if (bc_dec == 16'd0) begin
          phase_nxt = dra_pkg::PH_QLEN;
        end
      end
      dra_pkg::PH_QFIX: begin
        byte_counter_nxt = bc_dec;
        if (bc_dec == 16'd0) begin
          questions_left_nxt = cur_ql - 16'd1;
          if (questions_left_nxt != 16'd0) begin
            phase_nxt = dra_pkg::PH_QLEN;
          end else if (cur_al != 16'd0) begin
            phase_nxt = dra_pkg::PH_ALEN;
          end else begin
            phase_nxt = dra_pkg::PH_DONE;
          end
        end
      end
      dra_pkg::PH_ALEN: begin
        if ((b & dra_pkg::POINTER_MASK) != 8'd0) begin
          phase_nxt = dra_pkg::PH_APTR;
        end else if (b == 8'd0) begin
          byte_counter_nxt = dra_pkg::ANSWER_FIXED;
          phase_nxt        = dra_pkg::PH_AFIX;
        end else begin
          byte_counter_nxt = {8'd0, b};
          phase_nxt        = dra_pkg::PH_ASKIP;
        end
      end
      dra_pkg::PH_ASKIP: begin
        byte_counter_nxt = bc_dec;
        if (bc_dec == 16'd0) begin
          phase_nxt = dra_pkg::PH_ALEN;
        end
      end
      dra_pkg::PH_APTR: begin
        byte_counter_nxt = dra_pkg::ANSWER_FIXED;
        phase_nxt        = dra_pkg::PH_AFIX;
      end
      dra_pkg::PH_AFIX: begin
        byte_counter_nxt = bc_dec;
        if (bc_dec == 16'd0) begin
          phase_nxt = dra_pkg::PH_ALENHI;
        end
      end
      dra_pkg::PH_ALENHI: begin
        data_length_nxt = {b, 8'd0};
        phase_nxt       = dra_pkg::PH_ALENLO;
      end
      dra_pkg::PH_ALENLO: begin
        data_length_nxt    = dl_full;
        byte_counter_nxt   = '0;
        address_gather_nxt = '0;
        if (dl_full == 16'd0) begin
          answers_left_nxt = cur_al - 16'd1;
          answer_index_nxt = cur_ai + 16'd1;
          phase_nxt = (answers_left_nxt != 16'd0) ? dra_pkg::PH_ALEN : dra_pkg::PH_DONE;
        end else begin
          phase_nxt = dra_pkg::PH_ADATA;
        end
      end
      dra_pkg::PH_ADATA: begin
        if (cur_dl == dra_pkg::ADDR_BYTES) begin
          address_gather_nxt = ag_shift;
        end
        byte_counter_nxt = bc_inc;
        if (bc_inc >= cur_dl) begin
          res.valid        = (cur_dl == dra_pkg::ADDR_BYTES);
          answers_left_nxt = cur_al - 16'd1;
          answer_index_nxt = cur_ai + 16'd1;
          phase_nxt = (answers_left_nxt != 16'd0) ? dra_pkg::PH_ALEN : dra_pkg::PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= dra_pkg::PH_IDLE;
      byte_counter_r   <= '0;
      questions_left_r <= '0;
      answers_left_r   <= '0;
      data_length_r    <= '0;
      address_gather_r <= '0;
      answer_index_r   <= '0;
    end else if (step) begin
      phase_r          <= phase_nxt;
      byte_counter_r   <= byte_counter_nxt;
      questions_left_r <= questions_left_nxt;
      answers_left_r   <= answers_left_nxt;
      data_length_r    <= data_length_nxt;
      address_gather_r <= address_gather_nxt;
      answer_index_r   <= answer_index_nxt;
    end
  end

  // a result comes only from the last byte of a four-byte data field
  assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (phase_r == dra_pkg::PH_ADATA && !item.first_byte
                   && data_length_r == dra_pkg::ADDR_BYTES))
    else $error("address emitted outside a four-byte data field");

  // once done, only a start flag leaves the done phase
  assert property (@(posedge clk) disable iff (!rst_n)
    (step && !item.first_byte && phase_r == dra_pkg::PH_DONE) |=>
    phase_r == dra_pkg::PH_DONE)
    else $error("parse left done phase without a start");

endmodule

### hw/rtl/dra_out_buf.sv
// two-entry result buffer feeding the output channel
module dra_out_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dra_pkg::res_t res,
  output logic          space,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   ip_address,
  output logic [15:0]   answer_number
);

  logic [1:0]  count_r, count_nxt;
  logic [47:0] ent0_r, ent1_r;
  logic [47:0] wr_data;
  logic        pop;

  assign wr_data       = {res.answer_number, res.ip_address};
  assign out_valid     = (count_r != 2'd0);
  assign pop           = out_valid && out_ready;
  assign space         = (count_r != 2'd2);
  assign ip_address    = ent0_r[31:0];
  assign answer_number = ent0_r[47:32];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // entry shifting, head in entry 0
  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && count_r == 2'd1) begin
        ent0_r <= wr_data;
      end else begin
        ent0_r <= ent1_r;
      end
      if (push && count_r == 2'd2) begin
        ent1_r <= wr_data;
      end
    end else if (push) begin
      if (count_r == 2'd0) begin
        ent0_r <= wr_data;
      end else begin
        ent1_r <= wr_data;
      end
    end
  end

  // occupancy bound
  assert property (@(posedge clk) disable iff (!rst_n) count_r != 2'd3)
    else $error("result buffer count out of range");

  // no push into a full buffer
  assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != 2'd2))
    else $error("result pushed into full buffer");

endmodule

### hw/rtl/dns_response_address_parser.sv
// dns response parser extracting ipv4 addresses from answer records
// a byte is captured in the input register, parsed there while the result buffer has
// space, and its address, if any, is registered in the result buffer that drives out_
// throughput: one byte per cycle while the result buffer has space, set by the parse update
// a two-entry result buffer keeps input flowing while one result waits
// reset (rst_n low, synchronous) empties all stages and idles the parser
module dns_response_address_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] first_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [31:0] ip_address, [47:32] answer_number
);

  dra_pkg::item_t in_item;
  dra_pkg::item_t item;
  dra_pkg::res_t  res;
  logic           step;
  logic           space;
  logic [31:0]    ip_address;
  logic [15:0]    answer_number;

  assign in_item.data_byte  = in_tdata;
  assign in_item.first_byte = in_tuser;
  assign out_tdata          = {answer_number, ip_address};

  // input register
  dra_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .space    (space),
    .step     (step),
    .item     (item)
  );

  // parse state machine
  dra_parse_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item),
    .res   (res)
  );

  // result buffer
  dra_out_buf u_out_buf (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (step && res.valid),
    .res           (res),
    .space         (space),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .ip_address    (ip_address),
    .answer_number (answer_number)
  );

endmodule
